[sv/matrix_multiply_engine_top_assert.svh]
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top_assert.svh
// Assertion macros used by mme_back.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off during reset.
`define MME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off during reset.
`define MME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg
// Types, constants and helpers of the matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  localparam int MaxDim     = 8;
  localparam int DimCapInt  = (MaxDim > 8) ? 8 : ((MaxDim < 1) ? 1 : MaxDim);
  localparam logic [3:0] DimCap = 4'(DimCapInt);
  localparam int StoreDepth = 64;
  localparam int QueueDepth = 4;

  typedef enum logic [1:0] {
    ActWriteA  = 2'd0,
    ActWriteB  = 2'd1,
    ActCompute = 2'd2,
    ActNone    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CfgRowsM  = 2'd0,
    CfgInnerK = 2'd1,
    CfgColsN  = 2'd2,
    CfgUnused = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    action_e            op;
    logic [5:0]         index;
    logic signed [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [3:0] rows;
    logic [3:0] inner;
    logic [3:0] cols;
  } dims_t;

  function automatic logic [3:0] clamp_dim(input logic [3:0] v);
    logic [3:0] res;
    if (v == 4'd0) begin
      res = 4'd1;
    end else if (v > DimCap) begin
      res = DimCap;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/matrix_multiply_engine_top.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top
// Element loads: one beat per cycle while the queue is not full; each beat
// passes through the command queue and is written to a store when popped.
// Compute: walks m*n*k products through the single multiply-accumulate
// pipeline. Reset clears queue, sequencer and output valid; sizes reset to 1;
// stores hold unknown data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_engine_top #(
  parameter int QueueDepth = mme_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [5:0]         element_index_i,
  input  wire logic signed [15:0] element_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [34:0]      product_value_o,
  output logic [2:0]              result_row_o,
  output logic [2:0]              result_col_o,
  output logic                    last_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [3:0]         cfg_data_i
);

  mme_pkg::dims_t raw_q, dims;
  mme_pkg::cmd_t  push_cmd, head_cmd;
  logic push, full, head_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q.rows  <= 4'd1;
      raw_q.inner <= 4'd1;
      raw_q.cols  <= 4'd1;
    end else if (cfg_valid_i) begin
      unique case (mme_pkg::cfg_idx_e'(cfg_index_i))
        mme_pkg::CfgRowsM:  raw_q.rows  <= cfg_data_i;
        mme_pkg::CfgInnerK: raw_q.inner <= cfg_data_i;
        mme_pkg::CfgColsN:  raw_q.cols  <= cfg_data_i;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    dims.rows  = mme_pkg::clamp_dim(raw_q.rows);
    dims.inner = mme_pkg::clamp_dim(raw_q.inner);
    dims.cols  = mme_pkg::clamp_dim(raw_q.cols);
  end

  mme_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .full_i          (full)
  );

  mme_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (head_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  mme_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (head_valid),
    .cmd_i           (head_cmd),
    .cmd_pop_o       (pop),
    .dims_i          (dims),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .product_value_o (product_value_o),
    .result_row_o    (result_row_o),
    .result_col_o    (result_col_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

[sv/mme_front.sv]
// ----------------------------------------------------------------------------
// mme_front
// Accepts input beats, drops unused actions, turns the rest into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_front (
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [5:0]         element_index_i,
  input  wire logic signed [15:0] element_value_i,
  output logic                    push_o,
  output mme_pkg::cmd_t           cmd_o,
  input  wire logic               full_i
);

  mme_pkg::action_e act;

  always_comb begin
    act = mme_pkg::action_e'(action_i);
    in_stall_o = full_i;
    cmd_o.op = act;
    cmd_o.index = element_index_i;
    cmd_o.value = element_value_i;
    push_o = 1'b0;
    unique case (act) inside
      mme_pkg::ActWriteA, mme_pkg::ActWriteB, mme_pkg::ActCompute: push_o = in_valid_i && !full_i;
      default: push_o = 1'b0;  // drop: unused action
    endcase
  end

endmodule

`default_nettype wire

[sv/mme_queue.sv]
// ----------------------------------------------------------------------------
// mme_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_queue #(
  parameter int Depth = mme_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  mme_pkg::cmd_t      cmd_i,
  output logic               full_o,
  output logic               valid_o,
  output mme_pkg::cmd_t      cmd_o,
  input  wire logic          pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mme_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == CntW'(Depth));
    valid_o = (cnt_q != '0);
    cmd_o   = mem_q[rptr_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    cnt_d   = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[sv/mme_back.sv]
// ----------------------------------------------------------------------------
// mme_back
// Executes commands: element writes into the A and B stores, and products
// walked with one multiply-accumulate pipeline into a result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_multiply_engine_top_assert.svh"

module mme_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  input  mme_pkg::cmd_t           cmd_i,
  output logic                    cmd_pop_o,
  input  mme_pkg::dims_t          dims_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [34:0]      product_value_o,
  output logic [2:0]              result_row_o,
  output logic [2:0]              result_col_o,
  output logic                    last_o
);

  logic signed [15:0] left_mem  [mme_pkg::StoreDepth];
  logic signed [15:0] right_mem [mme_pkg::StoreDepth];

  logic busy_q, busy_d;
  logic [2:0] r_q, r_d, c_q, c_d, l_q, l_d;
  logic frz, adv, issue, wr_a, wr_b, start;
  logic l_end, c_end, r_end;
  logic [6:0] a_full, b_full;
  logic [5:0] addr_a, addr_b;

  // stage 1: read data
  logic signed [15:0] rd_a_q, rd_b_q;
  logic s1_vld_q, s1_first_q, s1_end_q, s1_last_q;
  logic [2:0] s1_row_q, s1_col_q;
  // stage 2: product
  logic signed [31:0] prod_q;
  logic s2_vld_q, s2_first_q, s2_end_q, s2_last_q;
  logic [2:0] s2_row_q, s2_col_q;
  // stage 3: accumulate
  logic signed [34:0] acc_q, acc_d;
  logic load;
  logic out_valid_q;
  logic signed [34:0] out_val_q;
  logic [2:0] out_row_q, out_col_q;
  logic out_last_q;

  always_comb begin
    frz   = out_valid_q && out_stall_i;
    adv   = !frz;
    cmd_pop_o = cmd_valid_i && !busy_q;
    start = cmd_pop_o && (cmd_i.op == mme_pkg::ActCompute);
    wr_a  = cmd_pop_o && (cmd_i.op == mme_pkg::ActWriteA);
    wr_b  = cmd_pop_o && (cmd_i.op == mme_pkg::ActWriteB);
    issue = busy_q && adv;

    l_end = ({1'b0, l_q} == dims_i.inner - 4'd1);
    c_end = ({1'b0, c_q} == dims_i.cols - 4'd1);
    r_end = ({1'b0, r_q} == dims_i.rows - 4'd1);

    a_full = 7'(r_q) * 7'(dims_i.inner) + 7'(l_q);
    b_full = 7'(l_q) * 7'(dims_i.cols) + 7'(c_q);
    addr_a = a_full[5:0];
    addr_b = b_full[5:0];

    busy_d = busy_q;
    r_d = r_q;
    c_d = c_q;
    l_d = l_q;
    if (start) begin
      busy_d = 1'b1;
      r_d = '0;
      c_d = '0;
      l_d = '0;
    end else if (issue) begin
      if (!l_end) begin
        l_d = l_q + 3'd1;
      end else begin
        l_d = '0;
        if (!c_end) begin
          c_d = c_q + 3'd1;
        end else begin
          c_d = '0;
          if (r_end) begin
            busy_d = 1'b0;
          end else begin
            r_d = r_q + 3'd1;
          end
        end
      end
    end

    acc_d = s2_first_q ? 35'(prod_q) : acc_q + 35'(prod_q);
    load  = adv && s2_vld_q && s2_end_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      left_mem[cmd_i.index] <= cmd_i.value;
    end
    if (wr_b) begin
      right_mem[cmd_i.index] <= cmd_i.value;
    end
    if (issue) begin
      rd_a_q <= left_mem[addr_a];
      rd_b_q <= right_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      r_q <= '0;
      c_q <= '0;
      l_q <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      r_q <= r_d;
      c_q <= c_d;
      l_q <= l_d;
      if (adv) begin
        s1_vld_q <= busy_q;
        s2_vld_q <= s1_vld_q;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload stages: hold everything while the result register is stalled.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_first_q <= (l_q == 3'd0);
      s1_end_q   <= l_end;
      s1_last_q  <= r_end && c_end;
      s1_row_q   <= r_q;
      s1_col_q   <= c_q;
      prod_q     <= rd_a_q * rd_b_q;
      s2_first_q <= s1_first_q;
      s2_end_q   <= s1_end_q;
      s2_last_q  <= s1_last_q;
      s2_row_q   <= s1_row_q;
      s2_col_q   <= s1_col_q;
      if (s2_vld_q) begin
        acc_q <= acc_d;
      end
    end
    if (load) begin
      out_val_q  <= acc_d;
      out_row_q  <= s2_row_q;
      out_col_q  <= s2_col_q;
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = out_val_q;
  assign result_row_o    = out_row_q;
  assign result_col_o    = out_col_q;
  assign last_o          = out_last_q;

  `MME_ASSERT_IMP(a_last_corner, out_valid_q && out_last_q,
    ({1'b0, out_row_q} == dims_i.rows - 4'd1) && ({1'b0, out_col_q} == dims_i.cols - 4'd1),
    "last flag away from final element")
  `MME_ASSERT_NXT(a_freeze_holds, busy_q && frz,
    busy_q && $stable(r_q) && $stable(c_q) && $stable(l_q),
    "sequencer advanced while result register stalled")
  `MME_ASSERT_IMP(a_no_write_busy, busy_q, !wr_a && !wr_b,
    "store written during a product walk")
  `MME_ASSERT_NXT(a_walk_ends, issue && l_end && c_end && r_end, !busy_q,
    "product walk did not stop after final element")

endmodule

`default_nettype wire
